>>> rtl/u8d_pkg.sv
// shared types, constants and the byte decode function of the utf-8 stream decoder
// used by the front, queue and back modules; depends on nothing else
package u8d_pkg;

   // byte class boundaries
   localparam logic [7:0] CONT_LO   = 8'h80;
   localparam logic [7:0] CONT_HI   = 8'hBF;
   localparam logic [7:0] LEAD2_LO  = 8'hC2;
   localparam logic [7:0] LEAD2_HI  = 8'hDF;
   localparam logic [7:0] LEAD3_LO  = 8'hE0;
   localparam logic [7:0] LEAD3_HI  = 8'hEF;
   localparam logic [7:0] LEAD_SURR = 8'hED;
   localparam logic [7:0] SPLIT_2ND = 8'hA0;
   localparam logic [15:0] BAD_MARK = 16'h003F;

   // results caused by one input beat, at most three
   typedef struct packed {
      logic [1:0]       count;
      logic [2:0][15:0] cp;
      logic [2:0]       bad;
      logic [2:0]       fin;
   } bundle_type;

   // full outcome of one decode step
   typedef struct packed {
      bundle_type      bundle;
      logic [1:0]      count;
      logic [1:0][7:0] bytes;
   } step_type;

   // queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic is_cont(input logic [7:0] b);
      return (b >= CONT_LO) && (b <= CONT_HI);
   endfunction

   // decode the held bytes plus one new byte
   function automatic step_type decode_step(input logic [1:0]      pcount,
                                            input logic [1:0][7:0] pbytes,
                                            input logic [7:0]      data,
                                            input logic            last);
      step_type        s;
      logic [2:0][7:0] buf_b;
      logic [1:0]      n;
      logic [1:0]      head;
      logic [1:0]      avail;
      logic [1:0]      k;
      logic [1:0]      rest;
      logic            done;
      logic            emit;
      logic            ebad;
      logic [15:0]     ecp;
      logic [1:0]      adv;
      logic [7:0]      b0;
      logic [7:0]      b1;
      logic [7:0]      b2;
      logic            ok1;
      s     = '0;
      buf_b = '0;
      head  = 2'd0;
      k     = 2'd0;
      done  = 1'b0;
      b1    = 8'h00;
      b2    = 8'h00;
      // line up held bytes and the new one
      case (pcount)
         2'd0: begin
            buf_b[0] = data;
         end
         2'd1: begin
            buf_b[0] = pbytes[0];
            buf_b[1] = data;
         end
         default: begin
            buf_b[0] = pbytes[0];
            buf_b[1] = pbytes[1];
            buf_b[2] = data;
         end
      endcase
      n = (pcount == 2'd0) ? 2'd1 : ((pcount == 2'd1) ? 2'd2 : 2'd3);
      // main decode, one sequence or one rejected byte per pass
      for (int i = 0; i < 3; i++) begin
         emit = 1'b0;
         ebad = 1'b0;
         ecp  = BAD_MARK;
         adv  = 2'd0;
         if (!done && (head < n)) begin
            b0    = buf_b[head];
            avail = n - head;
            if (b0 < CONT_LO) begin
               emit = 1'b1;
               ecp  = {8'h00, b0};
               adv  = 2'd1;
            end else if (b0 inside {[LEAD2_LO:LEAD2_HI]}) begin
               if (avail < 2'd2) begin
                  done = 1'b1;
               end else begin
                  b1   = buf_b[head + 2'd1];
                  emit = 1'b1;
                  if (is_cont(b1)) begin
                     ecp = {5'b00000, b0[4:0], b1[5:0]};
                     adv = 2'd2;
                  end else begin
                     ebad = 1'b1;
                     adv  = 2'd1;
                  end
               end
            end else if (b0 inside {[LEAD3_LO:LEAD3_HI]}) begin
               if (avail < 2'd2) begin
                  done = 1'b1;
               end else begin
                  b1  = buf_b[head + 2'd1];
                  ok1 = is_cont(b1) && !((b0 == LEAD3_LO) && (b1 < SPLIT_2ND)) &&
                        !((b0 == LEAD_SURR) && (b1 >= SPLIT_2ND));
                  if (!ok1) begin
                     emit = 1'b1;
                     ebad = 1'b1;
                     adv  = 2'd1;
                  end else if (avail < 2'd3) begin
                     done = 1'b1;
                  end else begin
                     b2   = buf_b[head + 2'd2];
                     emit = 1'b1;
                     if (is_cont(b2)) begin
                        ecp = {b0[3:0], b1[5:0], b2[5:0]};
                        adv = 2'd3;
                     end else begin
                        ebad = 1'b1;
                        adv  = 2'd1;
                     end
                  end
               end
            end else begin
               emit = 1'b1;
               ebad = 1'b1;
               adv  = 2'd1;
            end
         end
         if (emit) begin
            s.bundle.cp[k]  = ebad ? BAD_MARK : ecp;
            s.bundle.bad[k] = ebad;
            k    = k + 2'd1;
            head = head + adv;
         end
      end
      // end of text flushes the rest as errors
      for (int i = 0; i < 3; i++) begin
         if (last && (head < n)) begin
            s.bundle.cp[k]  = BAD_MARK;
            s.bundle.bad[k] = 1'b1;
            k    = k + 2'd1;
            head = head + 2'd1;
         end
      end
      if (last && (k != 2'd0)) begin
         s.bundle.fin[k - 2'd1] = 1'b1;
      end
      s.bundle.count = k;
      // keep what is still pending
      rest = n - head;
      if (!last && (rest >= 2'd1)) begin
         s.bytes[0] = buf_b[head];
      end
      if (!last && (rest >= 2'd2)) begin
         s.bytes[1] = buf_b[head + 2'd1];
      end
      s.count = last ? 2'd0 : rest;
      return s;
   endfunction

endpackage

>>> rtl/utf8_stream_decoder.sv
// top level of the utf-8 stream decoder: front, bundle queue and back
// depends on u8d_pkg, u8d_front, u8d_queue and u8d_back
//
// Takes one byte per cycle and gives 16-bit code points (one-, two- and three-byte
// forms); invalid bytes come out as 0x3F with rsp_bad_sequence set. A byte is
// decoded in the cycle it is accepted, together with up to two held bytes,
// and its zero to three results go into a two-entry queue; the back end sends one
// result per cycle while rsp_stall is low, from its output register, so the first
// result of a byte passes the queue entry and the output register before it reaches
// the rsp ports. Bytes that give one result or none flow at one per cycle while
// rsp_stall is low; a byte giving two or three results holds its queue entry until
// all are sent; once both entries are filled req_stall rises until one drains.
module utf8_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_point,
   output logic        rsp_bad_sequence,
   output logic        rsp_final_result
);

   u8d_pkg::q_status_type q_status;
   u8d_pkg::bundle_type   push_bundle;
   u8d_pkg::bundle_type   head_bundle;
   logic                  push;
   logic                  pop;

   u8d_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .q_status        (q_status),
      .push            (push),
      .push_bundle     (push_bundle)
   );

   u8d_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .q_status    (q_status),
      .head_bundle (head_bundle)
   );

   u8d_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .head_bundle      (head_bundle),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_point   (rsp_code_point),
      .rsp_bad_sequence (rsp_bad_sequence),
      .rsp_final_result (rsp_final_result)
   );

endmodule

>>> rtl/u8d_front.sv
// front end: accepts bytes, keeps the pending bytes and builds result bundles
// depends on u8d_pkg
module u8d_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_end_of_text,
   input  u8d_pkg::q_status_type q_status,
   output logic                  push,
   output u8d_pkg::bundle_type   push_bundle
);

   logic [1:0]       pend_count_ff;
   logic [1:0]       pend_count_in;
   logic [1:0][7:0]  pend_bytes_ff;
   logic [1:0][7:0]  pend_bytes_in;
   logic             accept;
   u8d_pkg::step_type step;

   // handshake
   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // decode of held bytes plus the new beat
   always_comb begin
      step = u8d_pkg::decode_step(pend_count_ff, pend_bytes_ff, req_data_byte,
                                  req_end_of_text);
   end

   assign push        = accept && (step.bundle.count != 2'd0);
   assign push_bundle = step.bundle;

   // pending state next value
   always_comb begin
      pend_count_in = pend_count_ff;
      pend_bytes_in = pend_bytes_ff;
      if (accept) begin
         pend_count_in = step.count;
         pend_bytes_in = step.bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_count_ff <= 2'd0;
      end else begin
         pend_count_ff <= pend_count_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_bytes_ff <= pend_bytes_in;
   end

endmodule

>>> rtl/u8d_queue.sv
// two-entry queue of result bundles between the front and back
// depends on u8d_pkg
module u8d_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  u8d_pkg::bundle_type   push_bundle,
   input  logic                  pop,
   output u8d_pkg::q_status_type q_status,
   output u8d_pkg::bundle_type   head_bundle
);

   u8d_pkg::bundle_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;

   // status and head
   assign q_status.full  = (fill_ff == 2'd2);
   assign q_status.empty = (fill_ff == 2'd0);
   assign head_bundle    = entry_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

>>> rtl/u8d_back.sv
// back end: walks each bundle one result at a time into the output register
// depends on u8d_pkg
module u8d_back (
   input  logic                  clock,
   input  logic                  reset,
   input  u8d_pkg::q_status_type q_status,
   input  u8d_pkg::bundle_type   head_bundle,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_code_point,
   output logic                  rsp_bad_sequence,
   output logic                  rsp_final_result
);

   logic        valid_ff;
   logic        valid_in;
   logic [1:0]  sel_ff;
   logic [1:0]  sel_in;
   logic [15:0] cp_ff;
   logic [15:0] cp_in;
   logic        bad_ff;
   logic        bad_in;
   logic        fin_ff;
   logic        fin_in;
   logic        load;
   logic        last_sel;

   // output register free or draining this cycle
   assign load     = !q_status.empty && (!valid_ff || !rsp_stall);
   assign last_sel = (sel_ff == (head_bundle.count - 2'd1));
   assign pop      = load && last_sel;

   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      cp_in    = cp_ff;
      bad_in   = bad_ff;
      fin_in   = fin_ff;
      if (load) begin
         valid_in = 1'b1;
         sel_in   = last_sel ? 2'd0 : (sel_ff + 2'd1);
         cp_in    = head_bundle.cp[sel_ff];
         bad_in   = head_bundle.bad[sel_ff];
         fin_in   = head_bundle.fin[sel_ff];
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff  <= cp_in;
      bad_ff <= bad_in;
      fin_ff <= fin_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_code_point   = cp_ff;
   assign rsp_bad_sequence = bad_ff;
   assign rsp_final_result = fin_ff;

endmodule

>>> rtl/u8d_checker.sv
// port-level checks of the utf-8 stream decoder, bound to the top level
// depends on utf8_stream_decoder ports only
module u8d_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_data_byte,
   input logic        req_end_of_text,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_code_point,
   input logic        rsp_bad_sequence,
   input logic        rsp_final_result
);

   // result beat stays up and unchanged while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_point) &&
         $stable(rsp_bad_sequence) && $stable(rsp_final_result))
      else $error("rsp beat dropped or changed while stalled");

   // stalled input beat is held by the sender
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data_byte) &&
         $stable(req_end_of_text))
      else $error("req beat dropped or changed while stalled");

   // reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // substituted results always carry the question mark
   a_bad_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_sequence |-> rsp_code_point == 16'h003F)
      else $error("bad sequence without substitute mark");

   // surrogate code points are never decoded
   a_no_surrogate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_sequence |-> rsp_code_point[15:11] != 5'b11011)
      else $error("surrogate code point decoded");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (.*);

>>> sim/utf8_result_checker.sv
// result checker for the utf-8 stream decoder: predicts code points from accepted input beats
// and compares every accepted result beat; standalone, needs no package
module utf8_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_text,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_code_point,
   input  logic        rsp_bad_sequence,
   input  logic        rsp_final_result,
   input  logic        check_leftover,
   output int          fail_count,
   output int          outstanding,
   output int          results_seen,
   output int          flagged_seen
);

   // byte classes of the decoder
   localparam logic [7:0]  TRAIL_LO    = 8'h80;
   localparam logic [7:0]  TRAIL_HI    = 8'hBF;
   localparam logic [7:0]  TWO_LO      = 8'hC2;
   localparam logic [7:0]  TWO_HI      = 8'hDF;
   localparam logic [7:0]  THREE_LO    = 8'hE0;
   localparam logic [7:0]  THREE_HI    = 8'hEF;
   localparam logic [7:0]  SURR_LEAD   = 8'hED;
   localparam logic [7:0]  SECOND_SPLIT = 8'hA0;
   localparam logic [15:0] BAD_POINT   = 16'h003F;
   localparam int          PRINT_LIMIT = 30;

   typedef struct packed {
      logic [15:0] code_point;
      logic        bad_sequence;
      logic        final_result;
   } point_t;

   // predictor state
   logic [1:0] held_count;
   logic [7:0] held_bytes [2];
   point_t     expected_points [$];
   bit         leftover_done;

   function automatic logic is_trail(input logic [7:0] b);
      return (b >= TRAIL_LO) && (b <= TRAIL_HI);
   endfunction

   function automatic point_t make_point(input logic [15:0] cp, input logic bad);
      point_t p;
      p.code_point   = cp;
      p.bad_sequence = bad;
      p.final_result = 1'b0;
      return p;
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_LIMIT) $display("mismatch: %s", msg);
      fail_count = fail_count + 1;
   endtask

   // decode held bytes plus the new one, queue the code points it completes
   task automatic decode_beat(input logic [7:0] data, input logic last);
      logic [7:0] seq [3];
      point_t     got [3];
      int         n;
      int         head;
      int         k;
      int         i;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic       ok1;
      logic       waiting;
      n = held_count;
      for (i = 0; i < n; i++) seq[i] = held_bytes[i];
      seq[n] = data;
      n = n + 1;
      head = 0;
      k = 0;
      waiting = 1'b0;
      while ((head < n) && !waiting) begin
         b0 = seq[head];
         if (b0 < TRAIL_LO) begin
            got[k] = make_point({8'h00, b0}, 1'b0);
            k = k + 1;
            head = head + 1;
         end else if ((b0 >= TWO_LO) && (b0 <= TWO_HI)) begin
            if (n - head < 2) begin
               waiting = 1'b1;
            end else begin
               b1 = seq[head + 1];
               if (is_trail(b1)) begin
                  got[k] = make_point({5'b00000, b0[4:0], b1[5:0]}, 1'b0);
                  head = head + 2;
               end else begin
                  got[k] = make_point(BAD_POINT, 1'b1);
                  head = head + 1;
               end
               k = k + 1;
            end
         end else if ((b0 >= THREE_LO) && (b0 <= THREE_HI)) begin
            if (n - head < 2) begin
               waiting = 1'b1;
            end else begin
               b1 = seq[head + 1];
               // overlong and surrogate forms die on the second byte
               ok1 = is_trail(b1) && !((b0 == THREE_LO) && (b1 < SECOND_SPLIT)) &&
                     !((b0 == SURR_LEAD) && (b1 >= SECOND_SPLIT));
               if (!ok1) begin
                  got[k] = make_point(BAD_POINT, 1'b1);
                  k = k + 1;
                  head = head + 1;
               end else if (n - head < 3) begin
                  waiting = 1'b1;
               end else begin
                  b2 = seq[head + 2];
                  if (is_trail(b2)) begin
                     got[k] = make_point({b0[3:0], b1[5:0], b2[5:0]}, 1'b0);
                     head = head + 3;
                  end else begin
                     got[k] = make_point(BAD_POINT, 1'b1);
                     head = head + 1;
                  end
                  k = k + 1;
               end
            end
         end else begin
            got[k] = make_point(BAD_POINT, 1'b1);
            k = k + 1;
            head = head + 1;
         end
      end
      // end of text flushes everything still held
      if (last) begin
         while (head < n) begin
            got[k] = make_point(BAD_POINT, 1'b1);
            k = k + 1;
            head = head + 1;
         end
         held_count = 2'd0;
         if (k > 0) got[k - 1].final_result = 1'b1;
      end else begin
         held_count = 2'(n - head);
         for (i = 0; i < n - head; i++) held_bytes[i] = seq[head + i];
      end
      for (i = 0; i < k; i++) expected_points.push_back(got[i]);
   endtask

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      results_seen  = 0;
      flagged_seen  = 0;
      held_count    = 2'd0;
      leftover_done = 1'b0;
   end

   // watch both channels at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         held_count = 2'd0;
      end else begin
         // result beat against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            results_seen = results_seen + 1;
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("unexpected result cp=%h bad=%b fin=%b",
                                         rsp_code_point, rsp_bad_sequence, rsp_final_result));
            end else begin
               if (expected_points[0].bad_sequence) flagged_seen = flagged_seen + 1;
               if (rsp_code_point !== expected_points[0].code_point)
                  report_mismatch($sformatf("result %0d code_point %h, expected %h",
                                            results_seen, rsp_code_point,
                                            expected_points[0].code_point));
               if (rsp_bad_sequence !== expected_points[0].bad_sequence)
                  report_mismatch($sformatf("result %0d bad_sequence %b, expected %b",
                                            results_seen, rsp_bad_sequence,
                                            expected_points[0].bad_sequence));
               if (rsp_final_result !== expected_points[0].final_result)
                  report_mismatch($sformatf("result %0d final_result %b, expected %b",
                                            results_seen, rsp_final_result,
                                            expected_points[0].final_result));
               void'(expected_points.pop_front());
            end
         end
         // input beat feeds the predictor
         if (req_valid && !req_stall) decode_beat(req_data_byte, req_end_of_text);
         // anything still waiting at the end is lost
         if (check_leftover && !leftover_done) begin
            leftover_done = 1'b1;
            if (expected_points.size() != 0)
               report_mismatch($sformatf("%0d expected results never arrived",
                                         expected_points.size()));
         end
      end
      outstanding = expected_points.size();
   end

endmodule

>>> sim/tb.sv
// testbench top for the utf-8 stream decoder: clock, reset, byte stimulus and verdict
// depends on utf8_stream_decoder and utf8_result_checker
module tb;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_end_of_text;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_code_point;
   logic        rsp_bad_sequence;
   logic        rsp_final_result;
   logic        check_leftover;
   int          fail_count;
   int          outstanding;
   int          results_seen;
   int          flagged_seen;
   int          bytes_sent;
   int          strings_ended;
   bit          quiet_idle;

   localparam int TARGET_BYTES = 270;
   localparam int DRAIN_LIMIT  = 20000;

   utf8_stream_decoder uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_point   (rsp_code_point),
      .rsp_bad_sequence (rsp_bad_sequence),
      .rsp_final_result (rsp_final_result)
   );

   utf8_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_point   (rsp_code_point),
      .rsp_bad_sequence (rsp_bad_sequence),
      .rsp_final_result (rsp_final_result),
      .check_leftover   (check_leftover),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .results_seen     (results_seen),
      .flagged_seen     (flagged_seen)
   );

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // hard limit on run length
   initial begin
      #3000000;
      $display("FAIL utf8_stream_decoder");
      $finish;
   end

   // idle length: mostly none or short, now and then long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // one input beat, then an optional gap
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_end_of_text <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent = bytes_sent + 1;
      if (last) strings_ended = strings_ended + 1;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // receiver back-pressure
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         hold = gap_len();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // stimulus and verdict
   initial begin
      logic [7:0] seq [3];
      int         len;
      int         r;
      int         j;
      int         waited;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data_byte   = 8'h00;
      req_end_of_text = 1'b0;
      check_leftover  = 1'b0;
      bytes_sent      = 0;
      strings_ended   = 0;
      quiet_idle      = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: ascii and zero byte
      send_byte(8'h41, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      // two- and three-byte extremes
      send_byte(8'hC2, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hDF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hE0, 1'b0);
      send_byte(8'hA0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      // overlong and surrogate rejected on the second byte
      send_byte(8'hE0, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'hED, 1'b0);
      send_byte(8'hA0, 1'b0);
      // stray leads
      send_byte(8'hC0, 1'b0);
      send_byte(8'hFF, 1'b0);
      // broken continuation, then broken third byte giving three results
      send_byte(8'hC2, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hE4, 1'b0);
      send_byte(8'hB8, 1'b0);
      send_byte(8'h41, 1'b0);
      // end of text flushing two held bytes, then on a plain byte
      send_byte(8'hE4, 1'b0);
      send_byte(8'hB8, 1'b1);
      send_byte(8'h7E, 1'b1);

      // random characters, mostly well formed
      while (bytes_sent < TARGET_BYTES) begin
         quiet_idle = ((bytes_sent / 40) % 4) == 3;
         r = $urandom_range(0, 99);
         len = 1;
         if (r < 25) begin
            seq[0] = 8'($urandom_range(1, 127));
         end else if (r < 50) begin
            seq[0] = 8'($urandom_range(8'hC2, 8'hDF));
            seq[1] = 8'($urandom_range(8'h80, 8'hBF));
            len = 2;
         end else if (r < 88) begin
            seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
            if (seq[0] == 8'hE0) seq[1] = 8'($urandom_range(8'hA0, 8'hBF));
            else if (seq[0] == 8'hED) seq[1] = 8'($urandom_range(8'h80, 8'h9F));
            else seq[1] = 8'($urandom_range(8'h80, 8'hBF));
            seq[2] = 8'($urandom_range(8'h80, 8'hBF));
            len = 3;
            // broken forms
            if (r >= 75) begin
               case ($urandom_range(0, 3))
                  0: begin
                     len = $urandom_range(1, 2);
                  end
                  1: begin
                     seq[$urandom_range(1, 2)] = 8'($urandom_range(1, 255));
                  end
                  2: begin
                     seq[0] = 8'hE0;
                     seq[1] = 8'($urandom_range(8'h80, 8'h9F));
                  end
                  default: begin
                     seq[0] = 8'hED;
                     seq[1] = 8'($urandom_range(8'hA0, 8'hBF));
                  end
               endcase
            end
         end else begin
            seq[0] = 8'($urandom_range(1, 255));
         end
         for (j = 0; j < len; j++) send_byte(seq[j], $urandom_range(0, 29) == 0);
      end
      quiet_idle = 1'b0;
      req_valid <= 1'b0;

      // drain, then wait for anything late
      waited = 0;
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited = waited + 1;
      end
      repeat (12) @(posedge clock);
      check_leftover <= 1'b1;
      repeat (3) @(posedge clock);

      $display("sent %0d bytes across %0d terminated strings, with random stalls on both sides",
               bytes_sent, strings_ended);
      $display("checked %0d code points, %0d of them substituted for invalid bytes",
               results_seen, flagged_seen);
      if (fail_count == 0) begin
         $display("PASS utf8_stream_decoder");
      end else begin
         $display("FAIL utf8_stream_decoder");
      end
      $finish;
   end

endmodule
